// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the hash table core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/dpht_pkg.sv
// Package for the depth-preferred hash table core: sizes, entry layout,
// command codes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package dpht_pkg;

  // Table size; must be a power of two so the slot is the low key bits
  localparam int TABLE_ENTRIES = 65536;
  localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);

  // Field widths
  localparam int KEY_BITS   = 64;
  localparam int SCORE_BITS = 18;
  localparam int DEPTH_BITS = 6;   // depth as given by a store
  localparam int SDEPTH_BITS = 7;  // stored depth, signed, -1 when empty
  localparam int BOUND_BITS = 2;
  localparam int MOVE_BITS  = 16;
  localparam int CMD_BITS   = 2;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_PROBE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_STORE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

  // One table entry as held in memory
  typedef struct packed {
    logic        [KEY_BITS-1:0]    key;
    logic signed [SCORE_BITS-1:0]  score;
    logic signed [SDEPTH_BITS-1:0] depth;
    logic        [BOUND_BITS-1:0]  bound;
    logic        [MOVE_BITS-1:0]   move;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Empty slot: key 0, score 0, depth -1
  localparam entry_t EMPTY_ENTRY = '{
    key:   '0,
    score: '0,
    depth: '1,
    bound: '0,
    move:  '0
  };

  // Controller states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

// File: design/dpht_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module dpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/depth_preferred_hash_table_core.sv
// Top level of the depth-preferred hash table core: controller, entry RAM
// and result register. Uses dpht_pkg, dpht_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------------
// req     | req_valid, req_stall | command, hash_key, entry_score, entry_depth,
//         |                      | bound_kind, move_word
// rsp     | rsp_valid, rsp_stall | hit, found_score, found_depth, found_bound,
//         |                      | found_move, written
//
// Probe and store each read the slot from the entry RAM, then compare, write
// back and load the result register.
// Clear sweeps the table: the RAM write port empties one entry per cycle, and
// the result word is loaded with the last entry.
// After reset the same sweep runs over all TABLE_ENTRIES (65536) entries with
// no result word; req_stall is high until it ends.
// A finished result waits in the result register; a new word is taken while
// it drains, but not while it is stalled.

module depth_preferred_hash_table_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic        [dpht_pkg::CMD_BITS-1:0]   command,
  input  logic        [dpht_pkg::KEY_BITS-1:0]   hash_key,
  input  logic signed [dpht_pkg::SCORE_BITS-1:0] entry_score,
  input  logic        [dpht_pkg::DEPTH_BITS-1:0] entry_depth,
  input  logic        [dpht_pkg::BOUND_BITS-1:0] bound_kind,
  input  logic        [dpht_pkg::MOVE_BITS-1:0]  move_word,
  // response channel
  output logic                                    rsp_valid,
  input  logic                                    rsp_stall,
  output logic                                    hit,
  output logic signed [dpht_pkg::SCORE_BITS-1:0]  found_score,
  output logic signed [dpht_pkg::SDEPTH_BITS-1:0] found_depth,
  output logic        [dpht_pkg::BOUND_BITS-1:0]  found_bound,
  output logic        [dpht_pkg::MOVE_BITS-1:0]   found_move,
  output logic                                    written
);

  dpht_pkg::state_t state, state_next;

  logic [dpht_pkg::INDEX_BITS-1:0] sweep_index;
  logic                            sweep_last;
  logic                            clear_pending;

  // latched request word
  logic        [dpht_pkg::CMD_BITS-1:0]   cmd_q;
  logic        [dpht_pkg::KEY_BITS-1:0]   key_q;
  logic signed [dpht_pkg::SCORE_BITS-1:0] score_q;
  logic        [dpht_pkg::DEPTH_BITS-1:0] depth_q;
  logic        [dpht_pkg::BOUND_BITS-1:0] bound_q;
  logic        [dpht_pkg::MOVE_BITS-1:0]  move_q;

  logic req_fire;
  logic rsp_fire;

  // RAM ports
  logic                            wr_en;
  logic [dpht_pkg::INDEX_BITS-1:0] wr_addr;
  dpht_pkg::entry_t                wr_data;
  logic [dpht_pkg::ENTRY_BITS-1:0] rd_raw;
  dpht_pkg::entry_t                entry_rd;

  // slot evaluation
  logic key_match;
  logic slot_empty;
  logic replace;

  // result register load
  logic                                    rsp_load;
  logic                                    hit_next;
  logic signed [dpht_pkg::SCORE_BITS-1:0]  score_next;
  logic signed [dpht_pkg::SDEPTH_BITS-1:0] depth_next;
  logic        [dpht_pkg::BOUND_BITS-1:0]  bound_next;
  logic        [dpht_pkg::MOVE_BITS-1:0]   move_next;
  logic                                    written_next;

  // handshakes
  assign req_stall = (state != dpht_pkg::ST_IDLE) || (rsp_valid && rsp_stall);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_fire  = rsp_valid && !rsp_stall;

  assign sweep_last = (sweep_index == dpht_pkg::INDEX_BITS'(dpht_pkg::TABLE_ENTRIES - 1));

  // entry RAM
  dpht_ram #(
    .WIDTH (dpht_pkg::ENTRY_BITS),
    .DEPTH (dpht_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (req_fire),
    .rd_addr (hash_key[dpht_pkg::INDEX_BITS-1:0]),
    .rd_data (rd_raw)
  );

  assign entry_rd = dpht_pkg::entry_t'(rd_raw);

  // compare the read slot against the latched request
  assign key_match  = (entry_rd.key == key_q);
  assign slot_empty = (entry_rd.key == '0);
  assign replace    = slot_empty ||
                      ($signed({1'b0, depth_q}) >= entry_rd.depth);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpht_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_next = dpht_pkg::ST_IDLE;
        end
      end
      dpht_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (command == dpht_pkg::CMD_CLEAR) begin
            state_next = dpht_pkg::ST_SWEEP;
          end else begin
            state_next = dpht_pkg::ST_LOOK;
          end
        end
      end
      dpht_pkg::ST_LOOK: begin
        state_next = dpht_pkg::ST_IDLE;
      end
      default: begin
        state_next = dpht_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM writes and result word
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = key_q[dpht_pkg::INDEX_BITS-1:0];
    wr_data      = '{key: key_q, score: score_q,
                     depth: dpht_pkg::SDEPTH_BITS'(depth_q),
                     bound: bound_q, move: move_q};
    rsp_load     = 1'b0;
    hit_next     = 1'b0;
    score_next   = '0;
    depth_next   = '0;
    bound_next   = '0;
    move_next    = '0;
    written_next = 1'b0;
    unique case (state)
      dpht_pkg::ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_index;
        wr_data = dpht_pkg::EMPTY_ENTRY;
        // a clear command answers with an all-zero word
        rsp_load = sweep_last && clear_pending;
      end
      dpht_pkg::ST_LOOK: begin
        rsp_load = 1'b1;
        unique case (cmd_q)
          dpht_pkg::CMD_PROBE: begin
            if (key_match) begin
              hit_next   = 1'b1;
              score_next = entry_rd.score;
              depth_next = entry_rd.depth;
              bound_next = entry_rd.bound;
              move_next  = entry_rd.move;
            end
          end
          dpht_pkg::CMD_STORE: begin
            wr_en        = replace;
            written_next = replace;
          end
          default: begin
            // unused code: all-zero word, no write
          end
        endcase
      end
      default: begin
        // idle: nothing to do
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dpht_pkg::ST_SWEEP;
      sweep_index   <= '0;
      clear_pending <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dpht_pkg::ST_SWEEP) begin
        sweep_index <= sweep_index + 1'b1;
      end
      if (req_fire && (command == dpht_pkg::CMD_CLEAR)) begin
        clear_pending <= 1'b1;
      end else if ((state == dpht_pkg::ST_SWEEP) && sweep_last) begin
        clear_pending <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request word capture
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q   <= command;
      key_q   <= hash_key;
      score_q <= entry_score;
      depth_q <= entry_depth;
      bound_q <= bound_kind;
      move_q  <= move_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      hit         <= hit_next;
      found_score <= score_next;
      found_depth <= depth_next;
      found_bound <= bound_next;
      found_move  <= move_next;
      written     <= written_next;
    end
  end

  // checks
  `ASSERT_SAME(a_rsp_load_free, rsp_load, !rsp_valid || !rsp_stall)
  `ASSERT_SAME(a_wr_only_store, wr_en && (state != dpht_pkg::ST_SWEEP), (state == dpht_pkg::ST_LOOK) && (cmd_q == dpht_pkg::CMD_STORE))
  `ASSERT_NEXT(a_fire_starts_work, req_fire, (state == dpht_pkg::ST_LOOK) || (state == dpht_pkg::ST_SWEEP))
  `ASSERT_SAME(a_written_no_hit, rsp_valid && written, !hit)

endmodule

// File: tb/depth_preferred_hash_table_core_tb.sv
// Testbench for depth_preferred_hash_table_core: directed and random probe, store and clear
// words, checked against a shadow table in the bench. Depends on dpht_pkg and the core RTL.
`timescale 1ns / 1ps

module depth_preferred_hash_table_core_tb;
  import dpht_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_RANDOM_CLEARS = 3;
  localparam int POOL_SLOTS = 12;
  localparam int POOL_TAGS = 3;

  localparam entry_t VACANT_SLOT = '{key: '0, score: '0, depth: '1, bound: '0, move: '0};

  // One response word as the bench expects it
  typedef struct packed {
    logic                          hit;
    logic signed [SCORE_BITS-1:0]  score;
    logic signed [SDEPTH_BITS-1:0] depth;
    logic        [BOUND_BITS-1:0]  bound;
    logic        [MOVE_BITS-1:0]   move;
    logic                          written;
  } lookup_result_t;

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_stall;
  logic        [CMD_BITS-1:0]    command;
  logic        [KEY_BITS-1:0]    hash_key;
  logic signed [SCORE_BITS-1:0]  entry_score;
  logic        [DEPTH_BITS-1:0]  entry_depth;
  logic        [BOUND_BITS-1:0]  bound_kind;
  logic        [MOVE_BITS-1:0]   move_word;
  logic                          rsp_valid;
  logic                          rsp_stall;
  logic                          hit;
  logic signed [SCORE_BITS-1:0]  found_score;
  logic signed [SDEPTH_BITS-1:0] found_depth;
  logic        [BOUND_BITS-1:0]  found_bound;
  logic        [MOVE_BITS-1:0]   found_move;
  logic                          written;

  // Shadow copy of the table; a missing index is an empty slot
  entry_t         shadow_slots[int unsigned];
  lookup_result_t pending_results[$];

  bit          idle_on;
  int unsigned cycle_count;
  int          mismatch_count;
  int          probe_count, store_count, clear_count, hit_count, written_count;
  int          random_clears;

  logic [INDEX_BITS-1:0]        slot_pool[POOL_SLOTS];
  logic [KEY_BITS-INDEX_BITS-1:0] tag_pool[POOL_TAGS];

  depth_preferred_hash_table_core dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .hash_key    (hash_key),
    .entry_score (entry_score),
    .entry_depth (entry_depth),
    .bound_kind  (bound_kind),
    .move_word   (move_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .found_score (found_score),
    .found_depth (found_depth),
    .found_bound (found_bound),
    .found_move  (found_move),
    .written     (written)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one word to the shadow table and return the response it should give
  function automatic lookup_result_t apply_to_shadow(
    logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
    logic signed [SCORE_BITS-1:0] score, logic [DEPTH_BITS-1:0] depth,
    logic [BOUND_BITS-1:0] bound, logic [MOVE_BITS-1:0] move);
    lookup_result_t r;
    entry_t         cur;
    int unsigned    slot;
    int             stored_depth;
    r = '0;
    slot = int'(key[INDEX_BITS-1:0]);
    cur = shadow_slots.exists(slot) ? shadow_slots[slot] : VACANT_SLOT;
    case (cmd)
      CMD_PROBE: begin
        if (cur.key == key) begin
          r.hit   = 1'b1;
          r.score = cur.score;
          r.depth = cur.depth;
          r.bound = cur.bound;
          r.move  = cur.move;
        end
      end
      CMD_STORE: begin
        stored_depth = cur.depth;  // sign-extends, -1 when empty
        if (cur.key == '0 || int'(depth) >= stored_depth) begin
          cur.key   = key;
          cur.score = score;
          cur.depth = $signed({1'b0, depth});
          cur.bound = bound;
          cur.move  = move;
          shadow_slots[slot] = cur;
          r.written = 1'b1;
        end
      end
      CMD_CLEAR: shadow_slots.delete();
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request word and wait for it to be taken
  task automatic push_request(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
                              logic signed [SCORE_BITS-1:0] score,
                              logic [DEPTH_BITS-1:0] depth,
                              logic [BOUND_BITS-1:0] bound, logic [MOVE_BITS-1:0] move);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid   <= 1'b1;
    command     <= cmd;
    hash_key    <= key;
    entry_score <= score;
    entry_depth <= depth;
    bound_kind  <= bound;
    move_word   <= move;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(apply_to_shadow(cmd, key, score, depth, bound, move));
    case (cmd)
      CMD_PROBE: probe_count++;
      CMD_STORE: store_count++;
      CMD_CLEAR: clear_count++;
      default: ;
    endcase
  endtask

  // Hold the sender off until every expected word has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Random key: mostly from a small pool so slots collide and keys repeat
  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return {$urandom, $urandom};
    if (r < 11) return '0;
    return {tag_pool[$urandom_range(0, POOL_TAGS - 1)],
            slot_pool[$urandom_range(0, POOL_SLOTS - 1)]};
  endfunction

  task automatic test_empty_table();
    // probe of key zero on an empty slot hits with depth -1
    push_request(CMD_PROBE, '0, '0, '0, '0, '0);
    push_request(CMD_PROBE, 64'h0123_4567_89AB_CDEF, '0, '0, '0, '0);
    push_request(CMD_PROBE, '1, '0, '0, '0, '0);
    // unused command does nothing
    push_request(CMD_UNUSED, 64'h0000_0001_0000_0005, 18'sh1FFFF, 6'd63, 2'd3, 16'hFFFF);
    push_request(CMD_PROBE, 64'h0000_0001_0000_0005, '0, '0, '0, '0);
  endtask

  task automatic test_replacement();
    logic [KEY_BITS-1:0] key_a, key_b;
    key_a = 64'hA5A5_0000_0000_1234;
    key_b = 64'h5A5A_0000_0000_1234;  // same slot as key_a
    push_request(CMD_STORE, key_a, -18'sd1000, 6'd5, 2'd1, 16'hBEEF);
    push_request(CMD_PROBE, key_a, '0, '0, '0, '0);
    // shallower store into an occupied slot is refused
    push_request(CMD_STORE, key_b, 18'sd7, 6'd4, 2'd2, 16'h1111);
    push_request(CMD_PROBE, key_b, '0, '0, '0, '0);
    // equal depth replaces
    push_request(CMD_STORE, key_b, 18'sd7, 6'd5, 2'd2, 16'h1111);
    push_request(CMD_PROBE, key_a, '0, '0, '0, '0);
    push_request(CMD_PROBE, key_b, '0, '0, '0, '0);
    // field extremes, bound kind 3 kept as given
    push_request(CMD_STORE, '1, -18'sd131072, 6'd0, 2'd3, 16'hFFFF);
    push_request(CMD_PROBE, '1, '0, '0, '0, '0);
    push_request(CMD_STORE, '1, 18'sd131071, 6'd63, 2'd0, 16'h0000);
    push_request(CMD_PROBE, '1, '0, '0, '0, '0);
    // a slot holding key zero counts as empty whatever its depth
    push_request(CMD_STORE, '0, 18'sd42, 6'd30, 2'd0, 16'h0042);
    push_request(CMD_PROBE, '0, '0, '0, '0, '0);
    push_request(CMD_STORE, 64'h0000_0000_0001_0000, 18'sd9, 6'd2, 2'd1, 16'h0009);
    push_request(CMD_PROBE, 64'h0000_0000_0001_0000, '0, '0, '0, '0);
    push_request(CMD_PROBE, '0, '0, '0, '0, '0);
  endtask

  task automatic test_clear();
    push_request(CMD_CLEAR, {$urandom, $urandom}, '0, '0, '0, '0);
    push_request(CMD_PROBE, 64'h5A5A_0000_0000_1234, '0, '0, '0, '0);
    push_request(CMD_PROBE, '1, '0, '0, '0, '0);
    push_request(CMD_PROBE, '0, '0, '0, '0, '0);
  endtask

  // Mostly probe and store traffic over the key pool, with rare clears and noise
  task automatic run_random_words(int count);
    logic [CMD_BITS-1:0]   cmd;
    logic [DEPTH_BITS-1:0] depth;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 999);
      if (r < 540) cmd = CMD_PROBE;
      else if (r < 970) cmd = CMD_STORE;
      else if (r < 997 || random_clears >= MAX_RANDOM_CLEARS) cmd = CMD_UNUSED;
      else cmd = CMD_CLEAR;
      if (cmd == CMD_CLEAR) random_clears++;
      depth = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 8));
      push_request(cmd, pick_key(), 18'($urandom), depth, 2'($urandom),
                   16'($urandom));
    end
  endtask

  // Receiver stalls in random bursts while idling is on
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted response word with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want, got;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = '{hit, found_score, found_depth, found_bound, found_move, written};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: response word with none expected: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: response mismatch\n  expected %p\n  actual   %p", want, got);
        end
        if (got.hit === 1'b1) hit_count++;
        if (got.written === 1'b1) written_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("FAIL depth_preferred_hash_table_core");
      $finish;
    end
  end

  initial begin
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    command     <= CMD_PROBE;
    hash_key    <= '0;
    entry_score <= '0;
    entry_depth <= '0;
    bound_kind  <= '0;
    move_word   <= '0;
    idle_on = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    random_clears = 0;
    for (int i = 0; i < POOL_SLOTS; i++) slot_pool[i] = INDEX_BITS'($urandom);
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (int i = 0; i < POOL_TAGS; i++) tag_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_replacement();
    test_clear();
    wait_for_results();

    idle_on = 1'b1;
    run_random_words(500);
    wait_for_results();
    run_random_words(300);
    idle_on = 1'b0;
    run_random_words(220);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d probes (%0d hits), %0d stores (%0d written), %0d clears",
             probe_count, hit_count, store_count, written_count, clear_count);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS depth_preferred_hash_table_core");
    end else begin
      $display("FAIL depth_preferred_hash_table_core");
    end
    $finish;
  end

endmodule
